// ----- hdl/prts_pkg.sv -----
`timescale 1ns / 1ps

package prts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int NUM_W     = 4;
  localparam int PARAM_W   = 16;
  localparam int TIME_W    = 32;
  localparam int STAMP_W   = TIME_W + 1;
  localparam int CNT_W     = 32;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_TASKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 1'd1;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_PARAM = 2'd2,
    ST_TIME_OUT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RUN
  } state_t;

endpackage

// ----- hdl/periodic_task_scheduler_rm_edf_top.sv -----
`timescale 1ns / 1ps
// Tick scheduler, one shared per-slot update/compare unit walked by a slot counter.
// Load, read and restart answer from S_EXEC; a tick walks S_SCAN over the
// n = min(num_tasks, 8) active slots (one slot per cycle), then answers from S_RUN.
// A new word is taken only in S_IDLE, after the last result is loaded for output.
// A waiting result does not block accept; a new result waits for the output register.
// Reset (rst, synchronous): clears state, valid, config, task parameters, time and job state at once.

module periodic_task_scheduler_rm_edf_top
  import prts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // task_index, period_in, rel_deadline_in, burst_in, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, idle, running_task, missed_mask, lost_count, completed_count,
  // killed, time_now, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t state, state_next;

  logic [NUM_W-1:0] num_tasks;
  logic             policy;
  logic [TIME_W-1:0] cur_time;

  logic [PARAM_W-1:0] task_period [MAX_TASKS];
  logic [PARAM_W-1:0] task_reld   [MAX_TASKS];
  logic [PARAM_W-1:0] task_burst  [MAX_TASKS];
  logic [PARAM_W-1:0] rem_work    [MAX_TASKS];
  logic [STAMP_W-1:0] next_arr    [MAX_TASKS];
  logic [STAMP_W-1:0] abs_dl      [MAX_TASKS];
  logic [CNT_W-1:0]   lost_jobs   [MAX_TASKS];
  logic [CNT_W-1:0]   done_jobs   [MAX_TASKS];

  // latched input word
  req_t               req;
  logic [2:0]         idx;
  logic [PARAM_W-1:0] p_in, d_in, c_in;

  // scan state
  logic [SLOT_W-1:0]  slot;
  logic               found;
  logic [SLOT_W-1:0]  sel;
  logic [STAMP_W-1:0] best;
  logic [MASK_W-1:0]  mask;

  // output register
  status_t            o_status;
  logic               o_idle;
  logic [2:0]         o_running;
  logic [MASK_W-1:0]  o_mask;
  logic [CNT_W-1:0]   o_lost, o_done;
  logic               o_killed;
  logic [TIME_W-1:0]  o_time;

  logic               out_free, out_load;
  logic [NUM_W-1:0]   n_active;
  logic               last_slot, time_max, bad_idx, load_ok;
  logic [SLOT_W-1:0]  addr;

  logic [PARAM_W-1:0] rd_period, rd_reld, rd_burst, rd_rem;
  logic [STAMP_W-1:0] rd_na, rd_ad;
  logic [CNT_W-1:0]   rd_lost, rd_done;

  logic [STAMP_W-1:0] t33, ad2, na2, key;
  logic               kill, rel, take;
  logic [PARAM_W-1:0] rem2;
  logic [CNT_W-1:0]   lost2;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign n_active = (num_tasks > NUM_W'(MAX_TASKS)) ? NUM_W'(MAX_TASKS) : num_tasks;
  assign last_slot = ({1'b0, slot} == n_active - NUM_W'(1));
  assign time_max  = (cur_time == '1);
  assign bad_idx   = (int'(idx) >= MAX_TASKS);
  assign load_ok   = (p_in != '0) && (d_in != '0) && (c_in != '0) &&
                     (c_in <= d_in) && (d_in <= p_in);

  always_comb begin
    case (state)
      S_SCAN:  addr = slot;
      S_RUN:   addr = sel;
      default: addr = idx[SLOT_W-1:0];
    endcase
  end

  assign rd_period = task_period[addr];
  assign rd_reld   = task_reld[addr];
  assign rd_burst  = task_burst[addr];
  assign rd_rem    = rem_work[addr];
  assign rd_na     = next_arr[addr];
  assign rd_ad     = abs_dl[addr];
  assign rd_lost   = lost_jobs[addr];
  assign rd_done   = done_jobs[addr];

  // per-slot unit: deadline kill, release, then candidate compare
  assign t33   = {1'b0, cur_time};
  assign kill  = (rd_rem != '0) && (rd_ad == t33);
  assign rel   = (rd_na == t33);
  assign rem2  = rel ? rd_burst : (kill ? '0 : rd_rem);
  assign ad2   = rel ? t33 + STAMP_W'(rd_reld) : rd_ad;
  assign na2   = rel ? rd_na + STAMP_W'(rd_period) : rd_na;
  assign lost2 = (kill && rd_lost != '1) ? rd_lost + CNT_W'(1) : rd_lost;
  assign key   = policy ? ad2 : STAMP_W'(rd_period);
  assign take  = (rem2 != '0) && (!found || key < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (req == REQ_TICK && !time_max) begin
          state_next = (n_active != '0) ? S_SCAN : S_RUN;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (last_slot) state_next = S_RUN;
      end
      S_RUN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req  <= req_t'(s_tuser);
      idx  <= s_tdata[2:0];
      p_in <= s_tdata[18:3];
      d_in <= s_tdata[34:19];
      c_in <= s_tdata[50:35];
    end
  end

  // configuration, task table and job state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_tasks <= '0;
      policy    <= 1'b0;
      cur_time  <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_period[i] <= '0;
        task_reld[i]   <= '0;
        task_burst[i]  <= '0;
        rem_work[i]    <= '0;
        next_arr[i]    <= '0;
        abs_dl[i]      <= '0;
        lost_jobs[i]   <= '0;
        done_jobs[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_TASKS: num_tasks <= cfg_data;
          REG_POLICY:    policy    <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_EXEC: begin
          if (out_free && req == REQ_RESTART) begin
            cur_time <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
              rem_work[i]  <= '0;
              next_arr[i]  <= '0;
              abs_dl[i]    <= '0;
              lost_jobs[i] <= '0;
              done_jobs[i] <= '0;
            end
          end else if (out_free && req == REQ_LOAD && !bad_idx && load_ok) begin
            task_period[addr] <= p_in;
            task_reld[addr]   <= d_in;
            task_burst[addr]  <= c_in;
          end
        end
        S_SCAN: begin
          rem_work[addr]  <= rem2;
          abs_dl[addr]    <= ad2;
          next_arr[addr]  <= na2;
          lost_jobs[addr] <= lost2;
        end
        S_RUN: begin
          if (out_free) begin
            cur_time <= cur_time + TIME_W'(1);
            if (found) begin
              rem_work[addr] <= rd_rem - PARAM_W'(1);
              if (rd_rem == PARAM_W'(1) && rd_done != '1)
                done_jobs[addr] <= rd_done + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // slot walk and selection
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      found <= 1'b0;
      sel   <= '0;
      mask  <= '0;
    end else if (state == S_EXEC) begin
      slot  <= '0;
      found <= 1'b0;
      sel   <= '0;
      mask  <= '0;
    end else if (state == S_SCAN) begin
      slot <= slot + SLOT_W'(1);
      if (kill) mask[slot] <= 1'b1;
      if (take) begin
        found <= 1'b1;
        sel   <= slot;
        best  <= key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status  <= ST_OK;
      o_idle    <= 1'b0;
      o_running <= '0;
      o_mask    <= '0;
      o_lost    <= '0;
      o_done    <= '0;
      o_killed  <= 1'b0;
      o_time    <= cur_time;
      if (state == S_RUN) begin
        o_idle    <= !found;
        o_running <= found ? 3'(sel) : 3'd0;
        o_mask    <= mask;
      end else begin
        case (req)
          REQ_TICK: begin
            o_status <= ST_TIME_OUT;
            o_idle   <= 1'b1;
          end
          REQ_LOAD: begin
            if (bad_idx)       o_status <= ST_BAD_INDEX;
            else if (!load_ok) o_status <= ST_BAD_PARAM;
          end
          REQ_READ: begin
            if (bad_idx) begin
              o_status <= ST_BAD_INDEX;
            end else begin
              o_lost   <= rd_lost;
              o_done   <= rd_done;
              o_killed <= (rd_rem != '0);
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign m_tdata = {1'b0, o_time, o_killed, o_done, o_lost, o_mask, o_running, o_idle,
                    o_status};

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, slot} < n_active))
    else $error("slot walk beyond active slots");

  a_run_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && found) |-> (rem_work[sel] != '0))
    else $error("selected job has no work");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && out_free) |=> (cur_time == $past(cur_time) + TIME_W'(1)))
    else $error("tick did not advance time");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && out_free && req == REQ_RESTART) |=> (cur_time == '0))
    else $error("restart did not clear time");

endmodule

// ----- tb/sv/sched_result_checker.sv -----
`timescale 1ns / 1ps

module sched_result_checker
  import prts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // task_index, period_in, rel_deadline_in, burst_in, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // status, idle, running_task, missed_mask, lost_count, completed_count,
  // killed, time_now, zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    checked,
  output int                    kills,
  output int                    idle_ticks
);

  // first member lands in the top bits, so status ends up at bit 0
  typedef struct packed {
    logic [TIME_W-1:0]  time_now;
    logic               killed;
    logic [CNT_W-1:0]   completed;
    logic [CNT_W-1:0]   lost;
    logic [MASK_W-1:0]  missed;
    logic [SLOT_W-1:0]  running;
    logic               idle;
    status_t            status;
  } sched_result_t;

  logic [NUM_W-1:0]   active_slots;
  logic               edf_mode;
  logic [TIME_W-1:0]  sched_time;
  logic [PARAM_W-1:0] slot_period   [MAX_TASKS];
  logic [PARAM_W-1:0] slot_deadline [MAX_TASKS];
  logic [PARAM_W-1:0] slot_burst    [MAX_TASKS];
  logic [PARAM_W-1:0] work_left     [MAX_TASKS];
  logic [STAMP_W-1:0] release_at    [MAX_TASKS];
  logic [STAMP_W-1:0] due_at        [MAX_TASKS];
  logic [CNT_W-1:0]   miss_count    [MAX_TASKS];
  logic [CNT_W-1:0]   done_count    [MAX_TASKS];

  sched_result_t pending_results[$];
  int err_count  = 0;
  int n_checked  = 0;
  int n_kills    = 0;
  int n_idle     = 0;

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    err_count++;
  endtask

  function automatic void clear_job_state();
    sched_time = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      work_left[i]  = '0;
      release_at[i] = '0;
      due_at[i]     = '0;
      miss_count[i] = '0;
      done_count[i] = '0;
    end
  endfunction

  function automatic sched_result_t schedule_step(input req_t req, input logic [SLOT_W-1:0] idx,
                                                  input logic [PARAM_W-1:0] p,
                                                  input logic [PARAM_W-1:0] d,
                                                  input logic [PARAM_W-1:0] c);
    sched_result_t r;
    int n;
    int sel;
    bit found;
    logic [MASK_W-1:0] mask;
    logic [STAMP_W-1:0] now_stamp;
    r = '0;
    r.time_now = sched_time;
    case (req)
      REQ_TICK: begin
        if (sched_time == '1) begin
          r.status = ST_TIME_OUT;
          r.idle = 1'b1;
          return r;
        end
        n = (int'(active_slots) < MAX_TASKS) ? int'(active_slots) : MAX_TASKS;
        now_stamp = {1'b0, sched_time};
        mask = '0;
        // kill before release so an overrun job at d == p is counted as lost
        for (int i = 0; i < n; i++) begin
          if (work_left[i] != 0 && due_at[i] == now_stamp) begin
            if (miss_count[i] != '1) miss_count[i]++;
            work_left[i] = '0;
            if (i < MASK_W) mask[i] = 1'b1;
          end
          if (release_at[i] == now_stamp) begin
            work_left[i]  = slot_burst[i];
            due_at[i]     = now_stamp + STAMP_W'(slot_deadline[i]);
            release_at[i] = release_at[i] + STAMP_W'(slot_period[i]);
          end
        end
        found = 1'b0;
        sel = 0;
        for (int i = 0; i < n; i++) begin
          if (work_left[i] == 0) continue;
          if (!found) begin
            found = 1'b1;
            sel = i;
          end else if (!edf_mode) begin
            if (slot_period[i] < slot_period[sel]) sel = i;
          end else begin
            if (due_at[i] < due_at[sel]) sel = i;
          end
        end
        if (found) begin
          work_left[sel] = work_left[sel] - 1'b1;
          if (work_left[sel] == 0 && done_count[sel] != '1) done_count[sel]++;
          r.running = SLOT_W'(sel);
        end else begin
          r.idle = 1'b1;
          n_idle++;
        end
        r.missed = mask;
        n_kills += $countones(mask);
        sched_time++;
      end
      REQ_RESTART: begin
        clear_job_state();
      end
      default: begin
        if (int'(idx) >= MAX_TASKS) begin
          r.status = ST_BAD_INDEX;
        end else if (req == REQ_LOAD) begin
          if (p == 0 || d == 0 || c == 0 || c > d || d > p) begin
            r.status = ST_BAD_PARAM;
          end else begin
            slot_period[idx]   = p;
            slot_deadline[idx] = d;
            slot_burst[idx]    = c;
          end
        end else begin
          r.lost      = miss_count[idx];
          r.completed = done_count[idx];
          r.killed    = (work_left[idx] != 0);
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_result(input sched_result_t want, input sched_result_t got);
    string tag;
    tag = $sformatf("word at time_now %0d:", want.time_now);
    if (got.status !== want.status)
      report_error($sformatf("%s status %0d, expected %0d", tag, got.status, want.status));
    if (got.idle !== want.idle)
      report_error($sformatf("%s idle %0d, expected %0d", tag, got.idle, want.idle));
    if (got.running !== want.running)
      report_error($sformatf("%s running_task %0d, expected %0d", tag, got.running,
                             want.running));
    if (got.missed !== want.missed)
      report_error($sformatf("%s missed_mask %h, expected %h", tag, got.missed, want.missed));
    if (got.lost !== want.lost)
      report_error($sformatf("%s lost_count %0d, expected %0d", tag, got.lost, want.lost));
    if (got.completed !== want.completed)
      report_error($sformatf("%s completed_count %0d, expected %0d", tag, got.completed,
                             want.completed));
    if (got.killed !== want.killed)
      report_error($sformatf("%s killed %0d, expected %0d", tag, got.killed, want.killed));
    if (got.time_now !== want.time_now)
      report_error($sformatf("%s time_now %0d", tag, got.time_now));
  endtask

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      active_slots = '0;
      edf_mode = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_period[i]   = '0;
        slot_deadline[i] = '0;
        slot_burst[i]    = '0;
      end
      clear_job_state();
      pending_results.delete();
    end else begin
      // output first: a word leaving now can't belong to one entering now
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(sched_result_t)-1:0];
        if (pending_results.size() == 0) begin
          report_error($sformatf("unexpected word, time_now %0d", got.time_now));
        end else begin
          want = pending_results.pop_front();
          compare_result(want, got);
          n_checked++;
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(schedule_step(req_t'(s_tuser), s_tdata[2:0], s_tdata[18:3],
                                                s_tdata[34:19], s_tdata[50:35]));
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_TASKS: active_slots = cfg_data[NUM_W-1:0];
          REG_POLICY:    edf_mode = cfg_data[0];
          default: ;
        endcase
      end
    end
    mismatches <= err_count;
    pending    <= pending_results.size();
    checked    <= n_checked;
    kills      <= n_kills;
    idle_ticks <= n_idle;
  end

endmodule

// ----- tb/sv/periodic_task_scheduler_rm_edf_top_tb.sv -----
`timescale 1ns / 1ps

module periodic_task_scheduler_rm_edf_top_tb;
  import prts_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_LEN     = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = REQ_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_TASKS;
  logic [CFG_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int checked;
  int kills;
  int idle_ticks;

  bit no_gaps    = 1'b0;
  bit hold_arm   = 1'b0;
  bit hold_done  = 1'b0;
  int hold_count = 0;
  int cycle_count = 0;
  int n_ticks = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_restarts = 0;

  periodic_task_scheduler_rm_edf_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sched_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .kills      (kills),
    .idle_ticks (idle_ticks)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: random stalls, one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      m_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_LEN - 1) hold_done <= 1'b1;
    end else begin
      m_tready <= no_gaps || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d words still outstanding", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input req_t req, input logic [2:0] idx, input logic [15:0] p,
                           input logic [15:0] d, input logic [15:0] c);
    while (!no_gaps && $urandom_range(0, 99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {5'd0, c, d, p, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (req)
      REQ_TICK:    n_ticks++;
      REQ_LOAD:    n_loads++;
      REQ_READ:    n_reads++;
      REQ_RESTART: n_restarts++;
      default: ;
    endcase
  endtask

  task automatic send_random_item();
    int roll;
    logic [15:0] p;
    logic [15:0] d;
    logic [15:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 68) begin
      send_item(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (roll < 78) begin
      send_item(REQ_READ, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (roll < 92) begin
      // well-formed task, mostly short periods so jobs release and collide often
      p = (roll < 88) ? 16'($urandom_range(1, 20)) : 16'($urandom_range(1, 65535));
      d = ($urandom_range(0, 2) == 0) ? p : 16'($urandom_range(1, p));
      c = 16'($urandom_range(1, d));
      send_item(REQ_LOAD, 3'($urandom), p, d, c);
    end else if (roll < 96) begin
      p = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      d = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      c = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      send_item(REQ_LOAD, 3'($urandom), p, d, c);
    end else begin
      send_item(REQ_RESTART, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] slots, input logic edf);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_TASKS;
    cfg_data  <= slots;
    @(posedge clk);
    cfg_index <= REG_POLICY;
    cfg_data  <= {3'd0, edf};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] slots, input logic edf, input int count);
    drain();
    write_config(slots, edf);
    send_item(REQ_RESTART, 3'd0, 16'd0, 16'd0, 16'd0);
    repeat (count - 1) send_random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no active slots after reset: the tick must come back idle
    send_item(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    drain();
    write_config(4'd3, 1'b0);
    send_item(REQ_LOAD, 3'd0, 16'd0, 16'd0, 16'd0);
    send_item(REQ_LOAD, 3'd1, 16'd10, 16'd5, 16'd6);
    send_item(REQ_LOAD, 3'd2, 16'd4, 16'd5, 16'd1);
    send_item(REQ_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(REQ_LOAD, 3'd0, 16'd4, 16'd4, 16'd2);
    // deadline equal to period, overloaded together with the others
    send_item(REQ_LOAD, 3'd1, 16'd6, 16'd6, 16'd3);
    send_item(REQ_LOAD, 3'd2, 16'd5, 16'd3, 16'd2);
    send_item(REQ_RESTART, 3'd0, 16'd0, 16'd0, 16'd0);
    repeat (12) send_item(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    send_item(REQ_READ, 3'd0, 16'd0, 16'd0, 16'd0);
    send_item(REQ_READ, 3'd1, 16'd0, 16'd0, 16'd0);
    send_item(REQ_READ, 3'd2, 16'd0, 16'd0, 16'd0);
    send_item(REQ_READ, 3'd7, 16'd0, 16'd0, 16'd0);

    run_phase(4'd3, 1'b0, 175);
    no_gaps = 1'b1;
    run_phase(4'd8, 1'b1, 175);
    no_gaps = 1'b0;
    // empty first so the hold-off lands on live traffic
    drain();
    hold_arm = 1'b1;
    run_phase(4'd15, 1'b0, 175);
    run_phase(4'd5, 1'b1, 150);
    run_phase(4'd0, 1'b1, 50);
    run_phase(4'd8, 1'b0, 150);
    drain();

    $display("Sent %0d words: %0d ticks, %0d loads, %0d reads, %0d restarts, 7 settings",
             n_ticks + n_loads + n_reads + n_restarts, n_ticks, n_loads, n_reads, n_restarts);
    $display("Checked %0d results with %0d deadline kills and %0d idle ticks",
             checked, kills, idle_ticks);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
